// ----- rtl/core/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants for the k-way merge min selector
// Sizes, op codes and the records passed along the cell row.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int NUM_RUNS  = 8;
  localparam int RUN_DEPTH = 256;

  localparam int KEY_W  = 64;
  localparam int SRC_W  = 3;   // width of run_index / source_run fields
  localparam int OP_W   = 2;

  localparam int RUN_W  = $clog2(NUM_RUNS);
  localparam int IDX_W  = (RUN_W > SRC_W) ? RUN_W : SRC_W;
  localparam int LEN_W  = $clog2(RUN_DEPTH + 1);
  localparam int ADDR_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CNT_W  = $clog2(NUM_RUNS + 1);

  localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [RUN_W-1:0] win;
    logic [KEY_W-1:0] best;
  } scan_t;

  localparam scan_t SCAN_START = '{hit: 1'b0, win: '0, best: KEY_ALL_ONES};

  // per-cell strobes from the sequencer
  typedef struct packed {
    logic wr;
    logic adv;
    logic clr;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/kwm_cell.sv -----
// ----------------------------------------------------------------------------
// kwm_cell: one run of the merge row
// Holds the run's key memory, length and cursor, keeps the head key
// registered and folds it into the running minimum passed down the row.
// ----------------------------------------------------------------------------
module kwm_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [kwm_pkg::RUN_W-1:0]    cell_idx,
  input  kwm_pkg::cell_ctrl_t          ctrl,
  input  logic [kwm_pkg::KEY_W-1:0]    key,
  input  kwm_pkg::scan_t               tok_in,
  output kwm_pkg::scan_t               tok_out
);

  logic [kwm_pkg::KEY_W-1:0] mem [kwm_pkg::RUN_DEPTH];

  logic [kwm_pkg::LEN_W-1:0] len_r;
  logic [kwm_pkg::LEN_W-1:0] cur_r;
  logic [kwm_pkg::KEY_W-1:0] head_r;
  kwm_pkg::scan_t            tok_r;
  kwm_pkg::scan_t            tok_nxt;

  logic not_full;
  logic live;

  assign not_full = (len_r < kwm_pkg::LEN_W'(kwm_pkg::RUN_DEPTH));
  assign live     = (cur_r < len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cur_r <= '0;
    end else if (ctrl.clr) begin
      len_r <= '0;
      cur_r <= '0;
    end else begin
      if (ctrl.wr && not_full) begin
        len_r <= len_r + kwm_pkg::LEN_W'(1);
      end
      if (ctrl.adv) begin
        cur_r <= cur_r + kwm_pkg::LEN_W'(1);
      end
    end
  end

  // key store: append at the tail, head read registered every cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr && not_full) begin
      mem[len_r[kwm_pkg::ADDR_W-1:0]] <= key;
    end
    head_r <= mem[cur_r[kwm_pkg::ADDR_W-1:0]];
  end

  // strict less-than: an earlier run keeps ties
  always_comb begin
    tok_nxt = tok_in;
    if (live && (head_r < tok_in.best)) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.win  = cell_idx;
      tok_nxt.best = head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= kwm_pkg::SCAN_START;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- rtl/core/k_way_merge_min_select.sv -----
// ----------------------------------------------------------------------------
// k_way_merge_min_select: merge of presorted runs by linear minimum search
// A row of run cells, each with its own key memory; a pop scans the row.
// ----------------------------------------------------------------------------
//
//  channel | ports         | contents (lowest bit first)
//  --------+---------------+------------------------------------------------
//  in      | in_tdata      | run_index[2:0], key_value[66:3], zero pad
//          | in_tuser      | op[1:0]  (0 append, 1 pop, 2 clear)
//  out     | out_tdata     | merged_key[63:0], source_run[66:64], zero pad
//          | out_tuser     | found[0]
//
//  Append, clear and the unused op leave the block idle; the block is ready
//  again on the next cycle.
//  A pop runs from accept to the result register as follows: the running
//  minimum moves one cell per cycle down the row, and once it has left the
//  last cell the result register is loaded. The head reads are already
//  registered when the pop is accepted.
//  After reset all runs are empty; no memory clearing pass is needed.
//  A result that is not taken holds the pop at its end; the next item is
//  still accepted once the result sits in the output register.
// ----------------------------------------------------------------------------
module k_way_merge_min_select (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // run_index[2:0], key_value[66:3], pad
  input  logic [1:0]  in_tuser,   // op[1:0]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // merged_key[63:0], source_run[66:64], pad
  output logic [0:0]  out_tuser   // found[0]
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                      state_r;
  logic [kwm_pkg::CNT_W-1:0]   cnt_r;

  logic                        out_valid_r;
  logic [kwm_pkg::KEY_W-1:0]   out_key_r;
  logic [kwm_pkg::SRC_W-1:0]   out_src_r;
  logic                        out_found_r;

  logic                        in_acc;
  logic                        scan_done;
  logic                        capture;
  logic [kwm_pkg::OP_W-1:0]    op;
  logic [kwm_pkg::SRC_W-1:0]   run_index;
  logic [kwm_pkg::KEY_W-1:0]   key_value;

  kwm_pkg::scan_t              tok [kwm_pkg::NUM_RUNS+1];
  kwm_pkg::cell_ctrl_t         ctrl [kwm_pkg::NUM_RUNS];
  logic [kwm_pkg::NUM_RUNS-1:0] wr_vec;
  logic [kwm_pkg::NUM_RUNS-1:0] adv_vec;
  kwm_pkg::scan_t              result;

  assign op        = in_tuser;
  assign run_index = in_tdata[kwm_pkg::SRC_W-1:0];
  assign key_value = in_tdata[kwm_pkg::SRC_W +: kwm_pkg::KEY_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // the last cell's token is settled once the count reaches NUM_RUNS
  assign result    = tok[kwm_pkg::NUM_RUNS];
  assign scan_done = (state_r == ST_SCAN) && (cnt_r == kwm_pkg::CNT_W'(kwm_pkg::NUM_RUNS));
  assign capture   = scan_done && (!out_valid_r || out_tready);

  assign tok[0] = kwm_pkg::SCAN_START;

  for (genvar i = 0; i < kwm_pkg::NUM_RUNS; i++) begin : g_cell
    assign wr_vec[i]  = in_acc && (op == kwm_pkg::OP_APPEND) &&
                        (kwm_pkg::IDX_W'(run_index) == kwm_pkg::IDX_W'(i));
    assign adv_vec[i] = capture && result.hit &&
                        (result.win == kwm_pkg::RUN_W'(i));
    assign ctrl[i].wr  = wr_vec[i];
    assign ctrl[i].adv = adv_vec[i];
    assign ctrl[i].clr = in_acc && (op == kwm_pkg::OP_CLEAR);

    kwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (kwm_pkg::RUN_W'(i)),
      .ctrl     (ctrl[i]),
      .key      (key_value),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (op == kwm_pkg::OP_POP)) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          if (!scan_done) begin
            cnt_r <= cnt_r + kwm_pkg::CNT_W'(1);
          end else if (capture) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (capture) begin
        out_valid_r <= 1'b1;
        out_key_r   <= result.hit ? result.best : kwm_pkg::KEY_ALL_ONES;
        out_src_r   <= result.hit ? kwm_pkg::SRC_W'(result.win) : '0;
        out_found_r <= result.hit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_src_r, out_key_r};
  assign out_tuser  = out_found_r;

  // no run changes while the row is settling a minimum
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((wr_vec == '0) && !ctrl[0].clr))
    else $error("run written during scan");

  // at most one cursor moves per pop
  a_adv_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(adv_vec))
    else $error("more than one cursor advanced");

  // a captured result is presented on the next cycle
  a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
    capture |=> out_valid_r)
    else $error("captured result not presented");

  // an empty answer is all ones from run zero
  a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |->
      ((out_key_r == kwm_pkg::KEY_ALL_ONES) && (out_src_r == '0)))
    else $error("malformed empty answer");

endmodule
